// ===== design/sri_pkg.sv =====
// shared types and constants of the slit ray intersection core
package sri_pkg;

    // configuration register file
    localparam int CFG_REGS  = 8;
    localparam int CFG_IDX_W = 3;

    // register indexes
    localparam int REG_OUTER_A_X = 0;
    localparam int REG_OUTER_A_Y = 1;
    localparam int REG_OUTER_B_X = 2;
    localparam int REG_OUTER_B_Y = 3;
    localparam int REG_GAP_A_X   = 4;
    localparam int REG_GAP_A_Y   = 5;
    localparam int REG_GAP_B_X   = 6;
    localparam int REG_GAP_B_Y   = 7;

    // per-ray flags carried alongside the divider
    typedef struct packed {
        logic hit;  // ray crosses a blocking segment
        logic par;  // denominator is zero
        logic neg;  // quotient is negative
    } t_flags;

endpackage

// ===== design/sri_div.sv =====
// pipelined restoring divider, one quotient bit per stage, with range check
module sri_div #(
    parameter int COORD_WIDTH   = 32,
    parameter int FRACTION_BITS = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  logic                         i_v,
    input  logic [2*COORD_WIDTH+2:0]     i_num,
    input  logic [2*COORD_WIDTH+2:0]     i_den,
    input  sri_pkg::t_flags              i_flags,
    output logic                         o_v,
    output logic [COORD_WIDTH:0]         o_q,
    output logic                         o_ovf,
    output sri_pkg::t_flags              o_flags
);

    localparam int CW = COORD_WIDTH;
    localparam int FB = FRACTION_BITS;
    localparam int MB = 2 * CW + 3;         // magnitude width
    localparam int NB = MB + FB;            // shifted numerator width
    localparam int RB = MB + 1;             // partial remainder width
    localparam int XB = MB + FB + CW + 2;   // range check width
    localparam int NS = CW + 1;             // quotient bits kept

    logic                 r_v     [NS+1];
    logic [RB-1:0]        r_rem   [NS+1];
    logic [CW:0]          r_q     [NS+1];
    logic [CW:0]          r_low   [NS+1];
    logic [MB-1:0]        r_den   [NS+1];
    logic                 r_ovf   [NS+1];
    sri_pkg::t_flags      r_flags [NS+1];

    logic [NB-1:0]        w_num_sh;
    logic [XB-1:0]        w_wide;
    logic                 w_ovf;
    logic [RB-1:0]        n_rem   [NS+1];
    logic [CW:0]          n_q     [NS+1];

    // entry stage: quotient beyond NS bits shows as num >= den << NS
    always_comb begin
        w_num_sh = NB'(i_num) << FB;
        w_ovf    = XB'(w_num_sh) >= (XB'(i_den) << NS);
        w_wide   = XB'(w_num_sh) >> NS;
    end

    // compare and subtract for each stage
    always_comb begin
        logic [RB:0] t_trial;
        logic [RB:0] t_diff;
        logic        t_ge;
        n_rem[0] = w_wide[RB-1:0];
        n_q[0]   = '0;
        t_trial  = '0;
        t_diff   = '0;
        t_ge     = 1'b0;
        for (int i = 1; i <= NS; i++) begin
            t_trial  = {r_rem[i-1], r_low[i-1][NS-i]};
            t_diff   = t_trial - (RB+1)'(r_den[i-1]);
            t_ge     = t_trial >= (RB+1)'(r_den[i-1]);
            n_rem[i] = t_ge ? t_diff[RB-1:0] : t_trial[RB-1:0];
            n_q[i]   = {r_q[i-1][CW-1:0], t_ge};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i <= NS; i++) begin
                r_v[i] <= 1'b0;
            end
        end else if (i_en) begin
            r_v[0] <= i_v;
            for (int i = 1; i <= NS; i++) begin
                r_v[i] <= r_v[i-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0]   <= n_rem[0];
            r_q[0]     <= n_q[0];
            r_low[0]   <= w_num_sh[CW:0];
            r_den[0]   <= i_den;
            r_ovf[0]   <= w_ovf;
            r_flags[0] <= i_flags;
            for (int i = 1; i <= NS; i++) begin
                r_rem[i]   <= n_rem[i];
                r_q[i]     <= n_q[i];
                r_low[i]   <= r_low[i-1];
                r_den[i]   <= r_den[i-1];
                r_ovf[i]   <= r_ovf[i-1];
                r_flags[i] <= r_flags[i-1];
            end
        end
    end

    assign o_v     = r_v[NS];
    assign o_q     = r_q[NS];
    assign o_ovf   = r_ovf[NS];
    assign o_flags = r_flags[NS];

endmodule

// ===== design/slit_ray_intersection_core.sv =====
// top level of the slit ray intersection core: ray tests, divider pipeline, output skid
//
// tests one ray (origin and direction, signed fixed point) against a slit made of two
// blocking segments on one line, outer_a..gap_a and outer_b..gap_b
// configuration: i_cfg_we writes i_cfg_data into register i_cfg_idx at the clock edge;
//   registers are outer_a x/y, outer_b x/y, gap_a x/y, gap_b x/y, all zero after reset;
//   write them only while no ray is in flight
// input channel: i_valid / o_ready, one ray per beat
// output channel: o_valid / i_ready, one result per ray, in order
//   miss: hits_blocker 0 and distance -1.0; parallel: distance 0;
//   otherwise distance is the ray parameter to the slit line, truncated and saturated
// throughput: one ray per clock cycle while o_ready is high
// the divider resolves one quotient bit per pipeline stage
// the datapath is the front register stages (differences, products, sides, magnitudes),
//   the divider stages and an output register, all moving on one common enable
// stall: when the receiver holds off, one further result lands in a skid register;
//   only then does o_ready drop and the whole pipeline freeze, nothing lost or repeated
// reset: synchronous, active low; clears the registers and empties the pipeline
module slit_ray_intersection_core #(
    parameter int COORD_WIDTH   = 32,
    parameter int FRACTION_BITS = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // configuration
    input  logic                            i_cfg_we,
    input  logic [sri_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [COORD_WIDTH-1:0]          i_cfg_data,
    // ray channel
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic signed [COORD_WIDTH-1:0]   i_ray_origin_x,
    input  logic signed [COORD_WIDTH-1:0]   i_ray_origin_y,
    input  logic signed [COORD_WIDTH-1:0]   i_ray_dir_x,
    input  logic signed [COORD_WIDTH-1:0]   i_ray_dir_y,
    // result channel
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic                            o_hits_blocker,
    output logic                            o_parallel,
    output logic                            o_saturated,
    output logic signed [COORD_WIDTH-1:0]   o_distance
);

    localparam int CW = COORD_WIDTH;
    localparam int FB = FRACTION_BITS;
    localparam int PW = 2 * CW + 2;     // product width
    localparam int XW = 2 * CW + 3;     // cross product difference width

    // endpoints of the slit
    localparam int NUM_EP     = 4;
    localparam int EP_OUTER_A = 0;
    localparam int EP_OUTER_B = 1;
    localparam int EP_GAP_A   = 2;
    localparam int EP_GAP_B   = 3;

    // distance limits and the miss value of -1.0, clamped into range
    localparam logic [CW-1:0] D_MAX  = {1'b0, {(CW-1){1'b1}}};
    localparam logic [CW-1:0] D_MIN  = {1'b1, {(CW-1){1'b0}}};
    localparam logic [CW-1:0] D_MISS = (FB >= CW - 1) ? D_MIN
                                                      : (CW'(0) - (CW'(1) << FB));
    localparam logic [CW:0]   Q_POS_MAX = {2'b00, {(CW-1){1'b1}}};
    localparam logic [CW:0]   Q_NEG_MAX = {2'b01, {(CW-1){1'b0}}};

    typedef struct packed {
        logic          hit;
        logic          par;
        logic          sat;
        logic [CW-1:0] distance;
    } t_result;

    function automatic logic signed [CW:0] f_sub(input logic signed [CW-1:0] a,
                                                 input logic signed [CW-1:0] b);
        f_sub = {a[CW-1], a} - {b[CW-1], b};
    endfunction

    // common pipeline enable: frozen only while the skid register is full
    logic en_g;

    // configuration registers
    logic signed [CW-1:0] r_cfg [sri_pkg::CFG_REGS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < sri_pkg::CFG_REGS; i++) begin
                r_cfg[i] <= '0;
            end
        end else if (i_cfg_we) begin
            r_cfg[i_cfg_idx] <= i_cfg_data;
        end
    end

    logic signed [CW-1:0] w_px [NUM_EP];
    logic signed [CW-1:0] w_py [NUM_EP];

    always_comb begin
        w_px[EP_OUTER_A] = r_cfg[sri_pkg::REG_OUTER_A_X];
        w_py[EP_OUTER_A] = r_cfg[sri_pkg::REG_OUTER_A_Y];
        w_px[EP_OUTER_B] = r_cfg[sri_pkg::REG_OUTER_B_X];
        w_py[EP_OUTER_B] = r_cfg[sri_pkg::REG_OUTER_B_Y];
        w_px[EP_GAP_A]   = r_cfg[sri_pkg::REG_GAP_A_X];
        w_py[EP_GAP_A]   = r_cfg[sri_pkg::REG_GAP_A_Y];
        w_px[EP_GAP_B]   = r_cfg[sri_pkg::REG_GAP_B_X];
        w_py[EP_GAP_B]   = r_cfg[sri_pkg::REG_GAP_B_Y];
    end

    // stage 1: coordinate differences
    logic                 r1_v;
    logic signed [CW:0]   r1_ex [NUM_EP];
    logic signed [CW:0]   r1_ey [NUM_EP];
    logic signed [CW:0]   r1_rax;
    logic signed [CW:0]   r1_ray;
    logic signed [CW:0]   r1_sdx;
    logic signed [CW:0]   r1_sdy;
    logic signed [CW-1:0] r1_dx;
    logic signed [CW-1:0] r1_dy;

    always_ff @(posedge i_clk) begin
        if (en_g) begin
            for (int e = 0; e < NUM_EP; e++) begin
                r1_ex[e] <= f_sub(w_px[e], i_ray_origin_x);
                r1_ey[e] <= f_sub(w_py[e], i_ray_origin_y);
            end
            r1_rax <= f_sub(i_ray_origin_x, w_px[EP_OUTER_A]);
            r1_ray <= f_sub(i_ray_origin_y, w_py[EP_OUTER_A]);
            r1_sdx <= f_sub(w_px[EP_OUTER_B], w_px[EP_OUTER_A]);
            r1_sdy <= f_sub(w_py[EP_OUTER_B], w_py[EP_OUTER_A]);
            r1_dx  <= i_ray_dir_x;
            r1_dy  <= i_ray_dir_y;
        end
    end

    // stage 2: products
    logic                 r2_v;
    logic signed [PW-1:0] r2_c1 [NUM_EP];
    logic signed [PW-1:0] r2_c2 [NUM_EP];
    logic signed [PW-1:0] r2_n1;
    logic signed [PW-1:0] r2_n2;
    logic signed [PW-1:0] r2_d1;
    logic signed [PW-1:0] r2_d2;

    always_ff @(posedge i_clk) begin
        if (en_g) begin
            for (int e = 0; e < NUM_EP; e++) begin
                r2_c1[e] <= r1_dy * r1_ex[e];
                r2_c2[e] <= r1_dx * r1_ey[e];
            end
            r2_n1 <= r1_sdx * r1_ray;
            r2_n2 <= r1_sdy * r1_rax;
            r2_d1 <= r1_sdy * r1_dx;
            r2_d2 <= r1_sdx * r1_dy;
        end
    end

    // stage 3: side of each endpoint, numerator and denominator
    logic                 r3_v;
    logic                 r3_pos [NUM_EP];
    logic                 r3_neg [NUM_EP];
    logic [XW-1:0]        r3_num;
    logic [XW-1:0]        r3_den;
    logic                 n3_pos [NUM_EP];
    logic                 n3_neg [NUM_EP];

    always_comb begin
        logic [XW-1:0] t_cross;
        t_cross = '0;
        for (int e = 0; e < NUM_EP; e++) begin
            t_cross   = {r2_c1[e][PW-1], r2_c1[e]} - {r2_c2[e][PW-1], r2_c2[e]};
            n3_neg[e] = t_cross[XW-1];
            n3_pos[e] = !t_cross[XW-1] && (t_cross != '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_g) begin
            for (int e = 0; e < NUM_EP; e++) begin
                r3_pos[e] <= n3_pos[e];
                r3_neg[e] <= n3_neg[e];
            end
            r3_num <= {r2_n1[PW-1], r2_n1} - {r2_n2[PW-1], r2_n2};
            r3_den <= {r2_d1[PW-1], r2_d1} - {r2_d2[PW-1], r2_d2};
        end
    end

    // stage 4: miss decision, parallel test, magnitudes and quotient sign
    logic                 r4_v;
    sri_pkg::t_flags      r4_flags;
    logic [XW-1:0]        r4_num;
    logic [XW-1:0]        r4_den;
    logic                 w_same_a;
    logic                 w_same_b;

    // an endpoint exactly on the ray line is on neither side
    assign w_same_a = (r3_pos[EP_OUTER_A] && r3_pos[EP_GAP_A])
                   || (r3_neg[EP_OUTER_A] && r3_neg[EP_GAP_A]);
    assign w_same_b = (r3_pos[EP_OUTER_B] && r3_pos[EP_GAP_B])
                   || (r3_neg[EP_OUTER_B] && r3_neg[EP_GAP_B]);

    always_ff @(posedge i_clk) begin
        if (en_g) begin
            r4_flags.hit <= !(w_same_a && w_same_b);
            r4_flags.par <= (r3_den == '0);
            r4_flags.neg <= r3_num[XW-1] ^ r3_den[XW-1];
            r4_num       <= r3_num[XW-1] ? (XW'(0) - r3_num) : r3_num;
            r4_den       <= r3_den[XW-1] ? (XW'(0) - r3_den) : r3_den;
        end
    end

    // valid bits of the front stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r4_v <= 1'b0;
        end else if (en_g) begin
            r1_v <= i_valid;
            r2_v <= r1_v;
            r3_v <= r2_v;
            r4_v <= r3_v;
        end
    end

    // divider pipeline
    logic                 dv_v;
    logic [CW:0]          dv_q;
    logic                 dv_ovf;
    sri_pkg::t_flags      dv_flags;

    sri_div #(
        .COORD_WIDTH   (COORD_WIDTH),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en_g),
        .i_v     (r4_v),
        .i_num   (r4_num),
        .i_den   (r4_den),
        .i_flags (r4_flags),
        .o_v     (dv_v),
        .o_q     (dv_q),
        .o_ovf   (dv_ovf),
        .o_flags (dv_flags)
    );

    // sign and saturation of the quotient
    t_result n_res;

    always_comb begin
        n_res.hit      = dv_flags.hit;
        n_res.par      = 1'b0;
        n_res.sat      = 1'b0;
        n_res.distance = '0;
        if (!dv_flags.hit) begin
            n_res.distance = D_MISS;
        end else if (dv_flags.par) begin
            n_res.par = 1'b1;
        end else if (dv_ovf) begin
            n_res.sat      = 1'b1;
            n_res.distance = dv_flags.neg ? D_MIN : D_MAX;
        end else if (!dv_flags.neg) begin
            if (dv_q > Q_POS_MAX) begin
                n_res.sat      = 1'b1;
                n_res.distance = D_MAX;
            end else begin
                n_res.distance = dv_q[CW-1:0];
            end
        end else begin
            if (dv_q > Q_NEG_MAX) begin
                n_res.sat      = 1'b1;
                n_res.distance = D_MIN;
            end else begin
                n_res.distance = CW'(0) - dv_q[CW-1:0];
            end
        end
    end

    // output register and skid register
    logic    r_ov;
    logic    r_sv;
    t_result r_out;
    t_result r_skid;

    assign en_g = !r_sv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
            r_sv <= 1'b0;
        end else if (en_g) begin
            if (!r_ov || i_ready) begin
                r_ov <= dv_v;
            end else if (dv_v) begin
                r_sv <= 1'b1;
            end
        end else if (i_ready) begin
            r_sv <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_g) begin
            if (!r_ov || i_ready) begin
                r_out <= n_res;
            end else begin
                r_skid <= n_res;
            end
        end else if (i_ready) begin
            r_out <= r_skid;
        end
    end

    assign o_ready        = en_g;
    assign o_valid        = r_ov;
    assign o_hits_blocker = r_out.hit;
    assign o_parallel     = r_out.par;
    assign o_saturated    = r_out.sat;
    assign o_distance     = r_out.distance;

    // the skid register only ever holds a beat behind a waiting output
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sv |-> r_ov)
        else $error("skid register full while output register empty");

    a_skid_fill_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_sv) |-> $past(r_ov && !i_ready))
        else $error("skid register filled without a stalled output");

    a_parallel_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_parallel) |-> (o_hits_blocker && !o_saturated && o_distance == '0))
        else $error("parallel result with hit, saturation or distance wrong");

    a_miss_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_hits_blocker) |-> (!o_parallel && !o_saturated
                                          && o_distance == D_MISS))
        else $error("miss result not reported as minus one");

    a_saturated_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_saturated) |-> (o_distance == D_MAX || o_distance == D_MIN))
        else $error("saturated distance not at a range limit");

endmodule

// ===== sim/tb_slit_ray_intersection_core.sv =====
// self-checking testbench of the slit ray intersection core: directed table, random rays
`timescale 1ns / 100ps

module tb_slit_ray_intersection_core;

    localparam int COORD_W     = 32;
    localparam int FRAC_BITS   = 16;
    localparam int ONE         = 1 << FRAC_BITS;
    // longest run of cycles with no beat on either channel before we give up
    localparam int STUCK_LIMIT = 2000;
    localparam int RAND_PHASES = 9;
    localparam int PHASE_RAYS  = 67;

    typedef logic signed [COORD_W-1:0] coord_t;
    // wide enough for a shifted difference of products of coordinate differences
    typedef logic signed [191:0] wide_t;

    typedef struct packed {
        coord_t org_x;
        coord_t org_y;
        coord_t dir_x;
        coord_t dir_y;
    } ray_t;

    typedef struct packed {
        logic   hits;
        logic   par;
        logic   sat;
        coord_t distance;
    } crossing_t;

    // slit geometries used by the directed table
    typedef enum int {SLIT_RESET, SLIT_NARROW, SLIT_DIAG, SLIT_CROSSED} slit_set_e;
    // how a random phase lays out its slit
    typedef enum int {PLAN_SLIT, PLAN_NOISE, PLAN_CORNERS} plan_e;

    typedef struct packed {
        slit_set_e slit;
        ray_t      ray;
        bit        typed;
        crossing_t want;
    } row_t;

    localparam coord_t CMAX = 32'sh7fff_ffff;
    localparam coord_t CMIN = 32'sh8000_0000;
    localparam wide_t  D_MAX = (wide_t'(1) <<< (COORD_W - 1)) - 1;
    localparam wide_t  D_MIN = -D_MAX - 1;

    // results that can be read straight off the geometry
    localparam crossing_t MISS     = '{hits: 1'b0, par: 1'b0, sat: 1'b0, distance: -ONE};
    localparam crossing_t PARALLEL = '{hits: 1'b1, par: 1'b1, sat: 1'b0, distance: '0};
    localparam crossing_t SAT_HI   = '{hits: 1'b1, par: 1'b0, sat: 1'b1, distance: CMAX};
    localparam crossing_t SAT_LO   = '{hits: 1'b1, par: 1'b0, sat: 1'b1, distance: CMIN};

    logic                            i_clk;
    logic                            i_rst_n;
    logic                            i_cfg_we;
    logic [sri_pkg::CFG_IDX_W-1:0]   i_cfg_idx;
    logic [COORD_W-1:0]              i_cfg_data;
    logic                            i_valid;
    logic                            o_ready;
    coord_t                          i_ray_origin_x;
    coord_t                          i_ray_origin_y;
    coord_t                          i_ray_dir_x;
    coord_t                          i_ray_dir_y;
    logic                            o_valid;
    logic                            i_ready;
    logic                            o_hits_blocker;
    logic                            o_parallel;
    logic                            o_saturated;
    coord_t                          o_distance;

    // the predictor's copy of the slit registers, and the next set to load
    coord_t    slit_regs [sri_pkg::CFG_REGS];
    coord_t    slit_plan [sri_pkg::CFG_REGS];
    crossing_t expected_crossings[$];
    row_t      dir_rows[$];
    int        mismatches = 0;
    bit        quiet      = 1'b0;

    // geometry of the current random slit: centre, step and the four endpoint positions
    int        slit_cx, slit_cy, slit_ux, slit_uy;
    int        slit_t [4];

    slit_ray_intersection_core #(
        .COORD_WIDTH   (COORD_W),
        .FRACTION_BITS (FRAC_BITS)
    ) DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_ray_origin_x (i_ray_origin_x),
        .i_ray_origin_y (i_ray_origin_y),
        .i_ray_dir_x    (i_ray_dir_x),
        .i_ray_dir_y    (i_ray_dir_y),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_hits_blocker (o_hits_blocker),
        .o_parallel     (o_parallel),
        .o_saturated    (o_saturated),
        .o_distance     (o_distance)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------

    function automatic wide_t widen(coord_t v);
        widen = v;
    endfunction

    // side of the ray line that point e lies on: -1, 0 on the line, +1
    function automatic int side_of(wide_t ex, wide_t ey, wide_t ox, wide_t oy,
                                   wide_t dx, wide_t dy);
        wide_t c;
        c = dy * (ex - ox) - dx * (ey - oy);
        return (c < 0) ? -1 : ((c == 0) ? 0 : 1);
    endfunction

    function automatic crossing_t predict_crossing(ray_t r);
        wide_t     ox, oy, dx, dy, ax, ay, bx, by, sdx, sdy, num, den, q;
        int        sa, sga, sb, sgb;
        crossing_t c;
        ox  = widen(r.org_x);
        oy  = widen(r.org_y);
        dx  = widen(r.dir_x);
        dy  = widen(r.dir_y);
        ax  = widen(slit_regs[sri_pkg::REG_OUTER_A_X]);
        ay  = widen(slit_regs[sri_pkg::REG_OUTER_A_Y]);
        bx  = widen(slit_regs[sri_pkg::REG_OUTER_B_X]);
        by  = widen(slit_regs[sri_pkg::REG_OUTER_B_Y]);
        sa  = side_of(ax, ay, ox, oy, dx, dy);
        sb  = side_of(bx, by, ox, oy, dx, dy);
        sga = side_of(widen(slit_regs[sri_pkg::REG_GAP_A_X]),
                      widen(slit_regs[sri_pkg::REG_GAP_A_Y]),
                      ox, oy, dx, dy);
        sgb = side_of(widen(slit_regs[sri_pkg::REG_GAP_B_X]),
                      widen(slit_regs[sri_pkg::REG_GAP_B_Y]),
                      ox, oy, dx, dy);
        c = '{hits: 1'b1, par: 1'b0, sat: 1'b0, distance: '0};
        // both blockers strictly on one side each: the ray slips past
        if (sa * sga > 0 && sb * sgb > 0) begin
            c = MISS;
        end else begin
            sdx = bx - ax;
            sdy = by - ay;
            num = sdx * (oy - ay) - sdy * (ox - ax);
            den = sdy * dx - sdx * dy;
            if (den == 0) begin
                c.par = 1'b1;
            end else begin
                // signed division truncates toward zero
                q = (num <<< FRAC_BITS) / den;
                if (q > D_MAX) begin
                    c.sat      = 1'b1;
                    c.distance = CMAX;
                end else if (q < D_MIN) begin
                    c.sat      = 1'b1;
                    c.distance = CMIN;
                end else begin
                    c.distance = q[COORD_W-1:0];
                end
            end
        end
        return c;
    endfunction

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------

    function automatic int rnd_span(int lim);
        return int'($urandom_range(2 * lim)) - lim;
    endfunction

    // mostly short gaps, now and then a long one; none at all in a quiet phase
    function automatic int idle_gap();
        int roll;
        if (quiet) return 0;
        roll = $urandom_range(99);
        if (roll < 55) return 0;
        if (roll < 85) return $urandom_range(3, 1);
        if (roll < 97) return $urandom_range(12, 4);
        return $urandom_range(60, 20);
    endfunction

    function automatic coord_t along_slit(int base, int step, int t);
        return coord_t'(longint'(base) + longint'(t) * step);
    endfunction

    function automatic coord_t corner_value();
        case ($urandom_range(4))
            0:       return CMIN;
            1:       return CMAX;
            2:       return '0;
            3:       return -1;
            default: return 1;
        endcase
    endfunction

    function automatic void set_plan(coord_t oax, coord_t oay, coord_t obx, coord_t oby,
                                     coord_t gax, coord_t gay, coord_t gbx, coord_t gby);
        slit_plan[sri_pkg::REG_OUTER_A_X] = oax;
        slit_plan[sri_pkg::REG_OUTER_A_Y] = oay;
        slit_plan[sri_pkg::REG_OUTER_B_X] = obx;
        slit_plan[sri_pkg::REG_OUTER_B_Y] = oby;
        slit_plan[sri_pkg::REG_GAP_A_X]   = gax;
        slit_plan[sri_pkg::REG_GAP_A_Y]   = gay;
        slit_plan[sri_pkg::REG_GAP_B_X]   = gbx;
        slit_plan[sri_pkg::REG_GAP_B_Y]   = gby;
    endfunction

    function automatic void table_row(slit_set_e slit, coord_t ox, coord_t oy,
                                      coord_t dx, coord_t dy, bit typed = 1'b0,
                                      crossing_t want = '0);
        dir_rows.push_back('{slit: slit, ray: '{ox, oy, dx, dy}, typed: typed, want: want});
    endfunction

    // random slit layout; the geometry is kept so that rays can be aimed at it
    task automatic plan_slit(plan_e how);
        slit_cx   = rnd_span(1 << 24);
        slit_cy   = rnd_span(1 << 24);
        slit_ux   = rnd_span(1 << 12);
        slit_uy   = rnd_span(1 << 12);
        if (slit_ux == 0 && slit_uy == 0) slit_ux = 1;
        // outer_a, gap_a, gap_b, outer_b along the line; the gap may close up
        slit_t[0] = -int'($urandom_range(1024, 64));
        slit_t[1] = -int'($urandom_range(63));
        slit_t[2] = int'($urandom_range(63));
        slit_t[3] = int'($urandom_range(1024, 64));
        case (how)
            PLAN_SLIT: begin
                set_plan(along_slit(slit_cx, slit_ux, slit_t[0]),
                         along_slit(slit_cy, slit_uy, slit_t[0]),
                         along_slit(slit_cx, slit_ux, slit_t[3]),
                         along_slit(slit_cy, slit_uy, slit_t[3]),
                         along_slit(slit_cx, slit_ux, slit_t[1]),
                         along_slit(slit_cy, slit_uy, slit_t[1]),
                         along_slit(slit_cx, slit_ux, slit_t[2]),
                         along_slit(slit_cy, slit_uy, slit_t[2]));
            end
            PLAN_NOISE: begin
                set_plan($urandom(), $urandom(), $urandom(), $urandom(),
                         $urandom(), $urandom(), $urandom(), $urandom());
            end
            default: begin
                set_plan(corner_value(), corner_value(), corner_value(), corner_value(),
                         corner_value(), corner_value(), corner_value(), corner_value());
            end
        endcase
    endtask

    function automatic ray_t next_ray();
        ray_t   r;
        int     kind, t, k, m;
        longint tx, ty;
        kind    = $urandom_range(99);
        r.org_x = coord_t'(slit_cx + rnd_span(1 << 24));
        r.org_y = coord_t'(slit_cy + rnd_span(1 << 24));
        r.dir_x = '0;
        r.dir_y = '0;
        if (kind < 15) begin
            // raw noise, every bit of every field
            r = {$urandom(), $urandom(), $urandom(), $urandom()};
        end else if (kind < 25) begin
            // running along the slit line
            m = rnd_span(64);
            if (m == 0) m = 1;
            r.dir_x = coord_t'(slit_ux * m);
            r.dir_y = coord_t'(slit_uy * m);
        end else if (kind < 30) begin
            // tiny direction, pushes the distance into saturation
            r.dir_x = coord_t'(rnd_span(3));
            r.dir_y = coord_t'(rnd_span(3));
        end else begin
            // aimed at a point on the line; exactly through an endpoint now and then
            if ($urandom_range(9) == 0) begin
                t = slit_t[$urandom_range(3)];
                k = 0;
            end else begin
                t = rnd_span(1500);
                k = $urandom_range(8);
            end
            tx      = longint'(slit_cx) + longint'(t) * slit_ux;
            ty      = longint'(slit_cy) + longint'(t) * slit_uy;
            r.dir_x = coord_t'((tx - r.org_x) >>> k);
            r.dir_y = coord_t'((ty - r.org_y) >>> k);
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // channel drivers
    // ------------------------------------------------------------------

    // write the planned slit once every ray in flight has come back
    task automatic load_slit();
        i_valid <= 1'b0;
        while (expected_crossings.size() != 0) @(posedge i_clk);
        for (int k = 0; k < sri_pkg::CFG_REGS; k++) begin
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= k[sri_pkg::CFG_IDX_W-1:0];
            i_cfg_data <= slit_plan[k];
            @(posedge i_clk);
            slit_regs[k] = slit_plan[k];
        end
        i_cfg_we <= 1'b0;
    endtask

    // one ray beat; valid stays up afterwards unless the next beat is held off
    task automatic send_ray(ray_t r, bit typed, crossing_t want);
        int gap;
        gap = idle_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid        <= 1'b1;
        i_ray_origin_x <= r.org_x;
        i_ray_origin_y <= r.org_y;
        i_ray_dir_x    <= r.dir_x;
        i_ray_dir_y    <= r.dir_y;
        do @(posedge i_clk); while (!o_ready);
        expected_crossings.push_back(typed ? want : predict_crossing(r));
    endtask

    task automatic check_field(string name, logic [COORD_W-1:0] want,
                               logic [COORD_W-1:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0d, got %0d",
                     $time, name, $signed(want), $signed(got));
            mismatches++;
        end
    endtask

    // ------------------------------------------------------------------
    // result side: checker and random back-pressure
    // ------------------------------------------------------------------

    initial begin
        crossing_t want;
        int        hold = 0;
        i_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (o_valid && i_ready) begin
                if (expected_crossings.size() == 0) begin
                    $display("%0t: unexpected result beat, distance %0d", $time, o_distance);
                    mismatches++;
                end else begin
                    want = expected_crossings.pop_front();
                    check_field("hits_blocker", want.hits, o_hits_blocker);
                    check_field("parallel", want.par, o_parallel);
                    check_field("saturated", want.sat, o_saturated);
                    check_field("distance", want.distance, o_distance);
                end
            end
            if (!i_rst_n) begin
                i_ready <= 1'b0;
            end else if (hold > 0) begin
                hold--;
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
                hold = idle_gap();
            end
        end
    end

    // watchdog: no beat on either channel for too long means a hang
    initial begin
        int stuck_cycles = 0;
        forever begin
            @(posedge i_clk);
            if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) begin
                stuck_cycles = 0;
            end else begin
                stuck_cycles++;
            end
            if (stuck_cycles >= STUCK_LIMIT) begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------

    initial begin
        row_t      row;
        slit_set_e cur;
        plan_e     how;
        i_rst_n        <= 1'b0;
        i_cfg_we       <= 1'b0;
        i_cfg_idx      <= '0;
        i_cfg_data     <= '0;
        i_valid        <= 1'b0;
        i_ray_origin_x <= '0;
        i_ray_origin_y <= '0;
        i_ray_dir_x    <= '0;
        i_ray_dir_y    <= '0;
        foreach (slit_regs[k]) slit_regs[k] = '0;

        // all endpoints at the origin after reset: a ray clear of it misses,
        // one through it hits a zero-length slit and is parallel
        table_row(SLIT_RESET, ONE, 0, 0, ONE, 1'b1, MISS);
        table_row(SLIT_RESET, 0, 0, ONE, 0, 1'b1, PARALLEL);
        table_row(SLIT_RESET, CMAX, CMAX, CMIN, CMIN);
        // vertical slit at x = 10, gap from y = -1 to y = 1
        table_row(SLIT_NARROW, 0, 0, ONE, 0, 1'b1, MISS);
        table_row(SLIT_NARROW, 0, 5 * ONE, ONE, 0);
        table_row(SLIT_NARROW, 0, 5 * ONE, 2 * ONE, 0);
        table_row(SLIT_NARROW, 0, -5 * ONE, -ONE, 0);
        // through a gap edge and through an outer edge exactly
        table_row(SLIT_NARROW, 0, -ONE, ONE, 0);
        table_row(SLIT_NARROW, 0, 10 * ONE, ONE, 0);
        // passes beyond the outer edge
        table_row(SLIT_NARROW, 0, 20 * ONE, ONE, 0, 1'b1, MISS);
        // along the slit line, and with no direction at all
        table_row(SLIT_NARROW, 10 * ONE, -5 * ONE, 0, ONE, 1'b1, PARALLEL);
        table_row(SLIT_NARROW, 0, 0, 0, 0, 1'b1, PARALLEL);
        // one-lsb direction: distance clamps both ways
        table_row(SLIT_NARROW, 0, 5 * ONE, 1, 0, 1'b1, SAT_HI);
        table_row(SLIT_NARROW, 0, 5 * ONE, -1, 0, 1'b1, SAT_LO);
        table_row(SLIT_NARROW, CMAX, CMAX, CMIN, CMIN);
        table_row(SLIT_NARROW, CMIN, CMIN, CMAX, CMAX);
        table_row(SLIT_NARROW, CMIN, CMAX, CMAX, CMIN);
        // diagonal slit spanning the whole coordinate range
        table_row(SLIT_DIAG, 0, 0, ONE, -ONE);
        table_row(SLIT_DIAG, CMAX, CMIN, CMIN, CMAX);
        table_row(SLIT_DIAG, ONE, 0, 0, ONE);
        // crossed corners with a closed gap at the origin
        table_row(SLIT_CROSSED, 0, ONE, ONE, 0);
        table_row(SLIT_CROSSED, CMIN, 0, CMAX, 1);
        table_row(SLIT_CROSSED, -1, -1, -1, -1);

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        cur = SLIT_RESET;
        foreach (dir_rows[n]) begin
            row = dir_rows[n];
            if (row.slit != cur) begin
                cur = row.slit;
                case (cur)
                    SLIT_NARROW: set_plan(10 * ONE, -10 * ONE, 10 * ONE, 10 * ONE,
                                          10 * ONE, -ONE, 10 * ONE, ONE);
                    SLIT_DIAG:   set_plan(CMIN, CMIN, CMAX, CMAX, -1, -1, 1, 1);
                    default:     set_plan(CMAX, CMIN, CMIN, CMAX, 0, 0, 0, 0);
                endcase
                load_slit();
            end
            send_ray(row.ray, row.typed, row.want);
        end

        // random phases, each with its own slit and its own idling mood
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            how   = (ph == 3) ? PLAN_NOISE : ((ph == 6) ? PLAN_CORNERS : PLAN_SLIT);
            quiet = ($urandom_range(3) == 0);
            plan_slit(how);
            load_slit();
            repeat (PHASE_RAYS) send_ray(next_ray(), 1'b0, '0);
        end

        i_valid <= 1'b0;
        while (expected_crossings.size() != 0) @(posedge i_clk);
        // room for any stray beat to show up
        repeat (COORD_W + 10) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

// ===== files.f =====
design/sri_pkg.sv
design/sri_div.sv
design/slit_ray_intersection_core.sv
sim/tb_slit_ray_intersection_core.sv
